>>> src/ubx_aiding_frame_builder_assert.svh
// Assertion macros used by the checker file.
`ifndef UBX_AIDING_FRAME_BUILDER_ASSERT_SVH
`define UBX_AIDING_FRAME_BUILDER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define UAFB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define UAFB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/uafb_pkg.sv
package uafb_pkg;

    localparam int IN_W   = 160;
    localparam int BYTE_W = 8;
    localparam int IDX_W  = 5;
    localparam int MUL_AW = 32;
    localparam int MUL_BW = 20;

    localparam logic [7:0] SYNC_1      = 8'hB5;
    localparam logic [7:0] SYNC_2      = 8'h62;
    localparam logic [7:0] MSG_CLASS   = 8'h13;
    localparam logic [7:0] MSG_ID      = 8'h40;
    localparam logic [7:0] LEN_POS     = 8'd20;
    localparam logic [7:0] LEN_TIME    = 8'd24;
    localparam logic [7:0] TYPE_POS    = 8'h01;
    localparam logic [7:0] TYPE_TIME   = 8'h10;
    localparam logic [IDX_W-1:0] LAST_POS  = 5'd27;
    localparam logic [IDX_W-1:0] LAST_TIME = 5'd31;

    localparam logic [MUL_BW-1:0] CM_PER_M  = 20'd100;
    localparam logic [MUL_BW-1:0] NS_PER_MS = 20'd1000000;
    localparam logic [31:0]       TACC_MAX_MS = 32'd4000;
    localparam logic [31:0]       TACC_COARSE = 32'hFFFF_FFFF;
    localparam logic [11:0]       YEAR_MIN = 12'd2024;
    localparam logic [11:0]       YEAR_MAX = 12'd2099;
    localparam logic [3:0]        MONTH_MAX = 4'd12;

    localparam logic CMD_POS  = 1'b0;
    localparam logic CMD_TIME = 1'b1;

    typedef struct packed {
        logic             clear;
        logic             add;
        logic [7:0]       data;
    } t_cks_ctrl;

    // Latched request fields used to build the frame body.
    typedef struct packed {
        logic        cmd;
        logic [31:0] lat;
        logic [31:0] lng;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } t_req;

    // Frame body byte at a given index; checksum bytes are supplied elsewhere.
    function automatic logic [7:0] frame_byte(input t_req req, input logic [IDX_W-1:0] idx,
                                              input logic [31:0] acc);
        logic [7:0] b;
        b = 8'h00;
        if (idx == 5'd0)      b = SYNC_1;
        else if (idx == 5'd1) b = SYNC_2;
        else if (idx == 5'd2) b = MSG_CLASS;
        else if (idx == 5'd3) b = MSG_ID;
        else if (req.cmd == CMD_POS) begin
            unique case (idx)
                5'd4:    b = LEN_POS;
                5'd6:    b = TYPE_POS;
                5'd10:   b = req.lat[7:0];
                5'd11:   b = req.lat[15:8];
                5'd12:   b = req.lat[23:16];
                5'd13:   b = req.lat[31:24];
                5'd14:   b = req.lng[7:0];
                5'd15:   b = req.lng[15:8];
                5'd16:   b = req.lng[23:16];
                5'd17:   b = req.lng[31:24];
                5'd22:   b = acc[7:0];
                5'd23:   b = acc[15:8];
                5'd24:   b = acc[23:16];
                5'd25:   b = acc[31:24];
                default: b = 8'h00;
            endcase
        end else begin
            unique case (idx)
                5'd4:    b = LEN_TIME;
                5'd6:    b = TYPE_TIME;
                5'd10:   b = req.year[7:0];
                5'd11:   b = {4'h0, req.year[11:8]};
                5'd12:   b = {4'h0, req.month};
                5'd13:   b = {3'h0, req.day};
                5'd14:   b = {3'h0, req.hour};
                5'd15:   b = {2'h0, req.minute};
                5'd16:   b = {2'h0, req.second};
                5'd26:   b = acc[7:0];
                5'd27:   b = acc[15:8];
                5'd28:   b = acc[23:16];
                5'd29:   b = acc[31:24];
                default: b = 8'h00;
            endcase
        end
        return b;
    endfunction

endpackage

>>> src/ubx_aiding_frame_builder.sv
// Channel | Dir | tdata (low bit up)                         | tuser | tlast
// s_axis  | in  | lat_e7 lng_e7 pos_accuracy_m year month day | cmd   | -
//         |     | hour minute second time_accuracy_ms, pad 160|       |
// m_axis  | out | out_byte                                   | -     | last_byte
//
// A request is set up (latch, shared multiply), then sends one frame byte
// per cycle unless m_axis stalls: 28 bytes for a position frame, 32 for a
// time frame, none if dropped. The multiplier is shared by both commands,
// the checksum adder by summed bytes; a single output register sends them.
// A stall on m_axis holds the sequencer. Reset is synchronous, active low.
module ubx_aiding_frame_builder (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // lat_e7[30:0] lng_e7[62:31] pos_accuracy_m[88:63] year_value[100:89]
    // month_value[104:101] day_value[109:105] hour_value[114:110]
    // minute_value[120:115] second_value[126:121] time_accuracy_ms[158:127]
    input  logic [uafb_pkg::IN_W-1:0]   i_s_axis_tdata,
    // cmd[0]
    input  logic                        i_s_axis_tuser,
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // out_byte[7:0]
    output logic [uafb_pkg::BYTE_W-1:0] o_m_axis_tdata,
    output logic                        o_m_axis_tlast
);
    import uafb_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_SEND = 2'd2;

    logic [1:0]       r_state;
    t_req             r_req;
    logic             r_ok;
    logic             r_coarse;
    logic [IDX_W-1:0] r_idx;
    logic             r_out_valid;
    logic [7:0]       r_out_data;
    logic             r_out_last;

    logic        in_cmd;
    logic [30:0] in_lat;
    logic [31:0] in_lng;
    logic [25:0] in_acc;
    logic [11:0] in_year;
    logic [3:0]  in_month;
    logic [4:0]  in_day;
    logic [31:0] in_tacc;
    logic        accept, in_ok, load;
    logic [IDX_W-1:0] last_idx;
    logic [31:0] product, acc_word;
    logic [7:0]  sum_a, sum_b, next_byte;
    t_cks_ctrl   cks_ctrl;

    assign in_cmd   = i_s_axis_tuser;
    assign in_lat   = i_s_axis_tdata[30:0];
    assign in_lng   = i_s_axis_tdata[62:31];
    assign in_acc   = i_s_axis_tdata[88:63];
    assign in_year  = i_s_axis_tdata[100:89];
    assign in_month = i_s_axis_tdata[104:101];
    assign in_day   = i_s_axis_tdata[109:105];
    assign in_tacc  = i_s_axis_tdata[158:127];

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign accept = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        if (in_cmd == CMD_POS) begin
            in_ok = (in_lat != 31'd0) || (in_lng != 32'd0);
        end else begin
            in_ok = (in_year >= YEAR_MIN) && (in_year <= YEAR_MAX) &&
                    (in_month != 4'd0) && (in_month <= MONTH_MAX) && (in_day != 5'd0);
        end
    end

    uafb_mul u_mul (
        .i_clk     (i_clk),
        .i_start   (accept),
        .i_a       ((in_cmd == CMD_TIME) ? in_tacc : {6'd0, in_acc}),
        .i_b       ((in_cmd == CMD_TIME) ? NS_PER_MS : CM_PER_M),
        .o_product (product)
    );

    assign last_idx = (r_req.cmd == CMD_TIME) ? LAST_TIME : LAST_POS;
    assign acc_word = (r_req.cmd == CMD_TIME && r_coarse) ? TACC_COARSE : product;
    assign load     = (r_state == ST_SEND) && (!r_out_valid || i_m_axis_tready);

    always_comb begin
        if (r_idx == last_idx - 5'd1)  next_byte = sum_a;
        else if (r_idx == last_idx)    next_byte = sum_b;
        else                           next_byte = frame_byte(r_req, r_idx, acc_word);
    end

    always_comb begin
        cks_ctrl.clear = accept;
        cks_ctrl.add   = load && (r_idx >= 5'd2) && (r_idx < last_idx - 5'd1);
        cks_ctrl.data  = next_byte;
    end

    uafb_fletcher u_fletcher (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (cks_ctrl),
        .o_sum_a (sum_a),
        .o_sum_b (sum_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: if (accept) r_state <= ST_MUL;
                ST_MUL:  r_state <= r_ok ? ST_SEND : ST_IDLE;
                ST_SEND: if (load && r_idx == last_idx) r_state <= ST_IDLE;
                default: r_state <= ST_IDLE;
            endcase
            if (load) r_out_valid <= 1'b1;
            else if (i_m_axis_tready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req.cmd    <= in_cmd;
            r_req.lat    <= {in_lat[30], in_lat};
            r_req.lng    <= in_lng;
            r_req.year   <= in_year;
            r_req.month  <= in_month;
            r_req.day    <= in_day;
            r_req.hour   <= i_s_axis_tdata[114:110];
            r_req.minute <= i_s_axis_tdata[120:115];
            r_req.second <= i_s_axis_tdata[126:121];
            r_ok         <= in_ok;
            r_coarse     <= (in_tacc > TACC_MAX_MS);
            r_idx        <= '0;
        end else if (load) begin
            r_idx <= r_idx + 5'd1;
        end
        if (load) begin
            r_out_data <= next_byte;
            r_out_last <= (r_idx == last_idx);
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_valid && r_out_last;

endmodule

>>> src/uafb_mul.sv
module uafb_mul (
    input  logic                          i_clk,
    input  logic                          i_start,
    input  logic [uafb_pkg::MUL_AW-1:0]   i_a,
    input  logic [uafb_pkg::MUL_BW-1:0]   i_b,
    output logic [31:0]                   o_product
);
    import uafb_pkg::*;

    logic [MUL_AW-1:0]        r_a;
    logic [MUL_BW-1:0]        r_b;
    logic [MUL_AW+MUL_BW-1:0] n_p;
    logic [31:0]              r_p;

    assign n_p = r_a * r_b;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
        end
        // keep the low word: the frame field wraps modulo 2^32
        r_p <= n_p[31:0];
    end

    assign o_product = r_p;

endmodule

>>> src/uafb_fletcher.sv
module uafb_fletcher (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  uafb_pkg::t_cks_ctrl   i_ctrl,
    output logic [7:0]            o_sum_a,
    output logic [7:0]            o_sum_b
);
    import uafb_pkg::*;

    logic [7:0] r_sum_a, r_sum_b;
    logic [7:0] n_sum_a, n_sum_b;

    always_comb begin
        n_sum_a = r_sum_a;
        n_sum_b = r_sum_b;
        if (i_ctrl.clear) begin
            n_sum_a = 8'h00;
            n_sum_b = 8'h00;
        end else if (i_ctrl.add) begin
            n_sum_a = r_sum_a + i_ctrl.data;
            n_sum_b = r_sum_b + n_sum_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_a <= 8'h00;
            r_sum_b <= 8'h00;
        end else begin
            r_sum_a <= n_sum_a;
            r_sum_b <= n_sum_b;
        end
    end

    assign o_sum_a = r_sum_a;
    assign o_sum_b = r_sum_b;

endmodule

>>> src/uafb_checker.sv
`include "ubx_aiding_frame_builder_assert.svh"

module uafb_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_s_axis_tvalid,
    input logic                        o_s_axis_tready,
    input logic                        o_m_axis_tvalid,
    input logic                        i_m_axis_tready,
    input logic [uafb_pkg::BYTE_W-1:0] o_m_axis_tdata,
    input logic                        o_m_axis_tlast
);
    import uafb_pkg::*;

    // a stalled output transaction holds its byte and end mark
    `UAFB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast), "output changed while stalled")

    // an accepted request keeps the input closed for at least the setup cycle
    `UAFB_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready, "ready right after accept")

    // when idle, only the closing byte of a frame may still wait at the output
    `UAFB_ASSERT_NOW(a_idle_only_last, i_clk, i_rst_n, o_s_axis_tready && o_m_axis_tvalid, o_m_axis_tlast, "idle with a frame byte pending")

endmodule

bind ubx_aiding_frame_builder uafb_checker u_uafb_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

>>> verif/tb_ubx_aiding_frame_builder.sv
`timescale 1ns / 1ps

module tb_ubx_aiding_frame_builder;
    import uafb_pkg::*;

    typedef struct {
        logic        cmd;
        logic [30:0] lat;
        logic [31:0] lng;
        logic [25:0] acc_m;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [31:0] tacc_ms;
    } t_aiding_req;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_frame_byte;

    typedef enum logic {ROW_PREDICT, ROW_NO_FRAME} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        t_aiding_req req;
    } t_dir_row;

    localparam int NUM_ROWS   = 21;
    localparam int PHASE_ITEMS = 136;
    localparam int DRAIN_LIMIT = 20000;
    localparam int TAIL_CYCLES = 40;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_s_axis_tvalid = 1'b0;
    logic               o_s_axis_tready;
    // lat_e7 lng_e7 pos_accuracy_m year month day hour minute second time_accuracy_ms, pad
    logic [IN_W-1:0]    i_s_axis_tdata = '0;
    // cmd
    logic               i_s_axis_tuser = 1'b0;
    logic               o_m_axis_tvalid;
    logic               i_m_axis_tready = 1'b0;
    // out_byte
    logic [BYTE_W-1:0]  o_m_axis_tdata;
    logic               o_m_axis_tlast;

    t_frame_byte        frame_bytes_due[$];
    int                 fail_count = 0;
    int                 src_idle_pct = 8;
    int                 sink_idle_pct = 68;

    ubx_aiding_frame_builder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("ubx_aiding_frame_builder verification failed");
        $finish;
    end

    // Build the frame a request should produce and queue its bytes.
    function automatic void predict_frame(input t_aiding_req r);
        logic [7:0]  fb [32];
        logic [31:0] lat32;
        logic [31:0] pos_cm;
        logic [31:0] tacc_ns;
        logic [7:0]  ck_a;
        logic [7:0]  ck_b;
        int          len;
        int          i;
        t_frame_byte fbt;
        for (i = 0; i < 32; i++) fb[i] = 8'h00;
        lat32 = {r.lat[30], r.lat};
        fb[0] = SYNC_1;
        fb[1] = SYNC_2;
        fb[2] = MSG_CLASS;
        fb[3] = MSG_ID;
        if (r.cmd == CMD_POS) begin
            if (lat32 == 32'd0 && r.lng == 32'd0) return;
            len = 28;
            pos_cm = {6'd0, r.acc_m} * 32'd100;
            fb[4] = LEN_POS;
            fb[6] = TYPE_POS;
            for (i = 0; i < 4; i++) begin
                fb[10 + i] = lat32[8*i +: 8];
                fb[14 + i] = r.lng[8*i +: 8];
                fb[22 + i] = pos_cm[8*i +: 8];
            end
        end else begin
            if (r.year < 12'd2024 || r.year > 12'd2099) return;
            if (r.month < 4'd1 || r.month > 4'd12 || r.day < 5'd1) return;
            len = 32;
            tacc_ns = (r.tacc_ms > 32'd4000) ? 32'hFFFF_FFFF : r.tacc_ms * 32'd1000000;
            fb[4]  = LEN_TIME;
            fb[6]  = TYPE_TIME;
            fb[10] = r.year[7:0];
            fb[11] = {4'h0, r.year[11:8]};
            fb[12] = {4'h0, r.month};
            fb[13] = {3'h0, r.day};
            fb[14] = {3'h0, r.hour};
            fb[15] = {2'h0, r.minute};
            fb[16] = {2'h0, r.second};
            for (i = 0; i < 4; i++) fb[26 + i] = tacc_ns[8*i +: 8];
        end
        ck_a = 8'h00;
        ck_b = 8'h00;
        for (i = 2; i < len - 2; i++) begin
            ck_a = ck_a + fb[i];
            ck_b = ck_b + ck_a;
        end
        fb[len - 2] = ck_a;
        fb[len - 1] = ck_b;
        for (i = 0; i < len; i++) begin
            fbt.data = fb[i];
            fbt.last = (i == len - 1);
            frame_bytes_due.push_back(fbt);
        end
    endfunction

    // Mostly in-range random requests, also zero coordinates, raw noise and broken dates.
    function automatic t_aiding_req random_request();
        t_aiding_req r;
        logic [31:0] v;
        int          pick;
        r.cmd = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            r.lat = '0;
            r.lng = '0;
        end else if (pick < 10) begin
            r.lat = 31'($urandom);
            r.lng = $urandom;
        end else begin
            v = $urandom_range(0, 1800000000) - 32'd900000000;
            r.lat = v[30:0];
            r.lng = $urandom_range(0, 32'd3600000000) - 32'd1800000000;
            if (pick < 13) r.lat = '0;
            else if (pick < 16) r.lng = '0;
        end
        r.acc_m = ($urandom_range(0, 9) == 0) ? 26'($urandom) : 26'($urandom_range(0, 42949672));
        r.year  = ($urandom_range(0, 9) == 0) ? 12'($urandom) : 12'($urandom_range(2024, 2099));
        r.month = ($urandom_range(0, 11) == 0) ? 4'($urandom) : 4'($urandom_range(1, 12));
        r.day   = ($urandom_range(0, 11) == 0) ? 5'($urandom) : 5'($urandom_range(1, 31));
        if ($urandom_range(0, 9) == 0) begin
            r.hour   = 5'($urandom);
            r.minute = 6'($urandom);
            r.second = 6'($urandom);
        end else begin
            r.hour   = 5'($urandom_range(0, 23));
            r.minute = 6'($urandom_range(0, 59));
            r.second = 6'($urandom_range(0, 60));
        end
        pick = $urandom_range(0, 9);
        if (pick < 4)      r.tacc_ms = $urandom_range(0, 4000);
        else if (pick < 5) r.tacc_ms = $urandom_range(3998, 4003);
        else               r.tacc_ms = $urandom;
        return r;
    endfunction

    // Offer one request, idling at random first; predict on the accepting edge.
    task automatic send_request(input t_aiding_req r, input logic predicted);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= r.cmd;
        i_s_axis_tdata  <= {1'b0, r.tacc_ms, r.second, r.minute, r.hour, r.day, r.month,
                            r.year, r.acc_m, r.lng, r.lat};
        do @(posedge i_clk); while (!o_s_axis_tready);
        if (predicted) predict_frame(r);
    endtask

    always @(negedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    always @(posedge i_clk) begin
        t_frame_byte exp_b;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (frame_bytes_due.size() == 0) begin
                $error("unexpected transaction: out_byte %02h last_byte %0b",
                       o_m_axis_tdata, o_m_axis_tlast);
                fail_count++;
            end else begin
                exp_b = frame_bytes_due.pop_front();
                if (o_m_axis_tdata !== exp_b.data) begin
                    $error("out_byte mismatch: expected %02h actual %02h",
                           exp_b.data, o_m_axis_tdata);
                    fail_count++;
                end
                if (o_m_axis_tlast !== exp_b.last) begin
                    $error("last_byte mismatch: expected %0b actual %0b",
                           exp_b.last, o_m_axis_tlast);
                    fail_count++;
                end
            end
        end
    end

    t_dir_row dir_rows [NUM_ROWS] = '{
        // position: typical, then zero position and single-zero coordinates
        '{ROW_PREDICT,  '{CMD_POS, 31'd123456789, 32'd987654321, 26'd15,
                          12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 32'd0}},
        '{ROW_NO_FRAME, '{CMD_POS, 31'd0, 32'd0, 26'd77,
                          12'd2050, 4'd6, 5'd15, 5'd1, 6'd2, 6'd3, 32'd10}},
        '{ROW_PREDICT,  '{CMD_POS, 31'd0, 32'd1, 26'd0,
                          12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 32'd0}},
        '{ROW_PREDICT,  '{CMD_POS, 31'd1, 32'd0, 26'd1,
                          12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 32'd0}},
        // coordinate and accuracy extremes, full-width wrap of the accuracy
        '{ROW_PREDICT,  '{CMD_POS, 31'd900000000, 32'd1800000000, 26'd42949672,
                          12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 32'd0}},
        '{ROW_PREDICT,  '{CMD_POS, -31'sd900000000, -32'sd1800000000, 26'd0,
                          12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 32'd0}},
        '{ROW_PREDICT,  '{CMD_POS, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 26'h3FF_FFFF,
                          12'hFFF, 4'hF, 5'h1F, 5'h1F, 6'h3F, 6'h3F, 32'hFFFF_FFFF}},
        '{ROW_PREDICT,  '{CMD_POS, 31'h4000_0000, 32'h8000_0000, 26'd42949673,
                          12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 32'd0}},
        // time: date range edges and accuracy threshold
        '{ROW_PREDICT,  '{CMD_TIME, 31'd0, 32'd0, 26'd0,
                          12'd2024, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 32'd0}},
        '{ROW_PREDICT,  '{CMD_TIME, 31'd0, 32'd0, 26'd0,
                          12'd2099, 4'd12, 5'd31, 5'd23, 6'd59, 6'd60, 32'd4000}},
        '{ROW_PREDICT,  '{CMD_TIME, 31'd5, 32'd6, 26'd7,
                          12'd2030, 4'd7, 5'd4, 5'd12, 6'd30, 6'd15, 32'd4001}},
        '{ROW_PREDICT,  '{CMD_TIME, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 26'h3FF_FFFF,
                          12'd2075, 4'd2, 5'd29, 5'd6, 6'd7, 6'd8, 32'hFFFF_FFFF}},
        // bad dates
        '{ROW_NO_FRAME, '{CMD_TIME, 31'd0, 32'd0, 26'd0,
                          12'd2023, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 32'd1}},
        '{ROW_NO_FRAME, '{CMD_TIME, 31'd0, 32'd0, 26'd0,
                          12'd2100, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 32'd1}},
        '{ROW_NO_FRAME, '{CMD_TIME, 31'd0, 32'd0, 26'd0,
                          12'd2050, 4'd0, 5'd10, 5'd0, 6'd0, 6'd0, 32'd1}},
        '{ROW_NO_FRAME, '{CMD_TIME, 31'd0, 32'd0, 26'd0,
                          12'd2050, 4'd13, 5'd10, 5'd0, 6'd0, 6'd0, 32'd1}},
        '{ROW_NO_FRAME, '{CMD_TIME, 31'd0, 32'd0, 26'd0,
                          12'd2050, 4'd5, 5'd0, 5'd0, 6'd0, 6'd0, 32'd1}},
        '{ROW_NO_FRAME, '{CMD_TIME, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 26'h3FF_FFFF,
                          12'hFFF, 4'hF, 5'h1F, 5'h1F, 6'h3F, 6'h3F, 32'hFFFF_FFFF}},
        '{ROW_NO_FRAME, '{CMD_TIME, 31'd0, 32'd0, 26'd0,
                          12'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 32'd0}},
        // time of day sent unchecked, then a position with its date fields set
        '{ROW_PREDICT,  '{CMD_TIME, 31'd0, 32'd0, 26'd0,
                          12'd2048, 4'd8, 5'd16, 5'h1F, 6'h3F, 6'h3F, 32'd3999}},
        '{ROW_PREDICT,  '{CMD_POS, 31'h2AAA_AAAA, 32'h5555_5555, 26'h155_5555,
                          12'd2050, 4'd6, 5'd15, 5'd1, 6'd2, 6'd3, 32'd10}}
    };

    initial begin
        int sent;
        int phase;
        int waited;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < NUM_ROWS; k++) begin
            send_request(dir_rows[k].req, dir_rows[k].kind == ROW_PREDICT);
        end

        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin src_idle_pct = 8;  sink_idle_pct = 68; end
                1: begin src_idle_pct = 68; sink_idle_pct = 8;  end
                default: begin src_idle_pct = 0; sink_idle_pct = 0; end
            endcase
            for (sent = 0; sent < PHASE_ITEMS; sent++) begin
                send_request(random_request(), 1'b1);
            end
        end
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;

        waited = 0;
        while (frame_bytes_due.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (frame_bytes_due.size() != 0) begin
            $error("%0d expected frame bytes never arrived", frame_bytes_due.size());
            fail_count++;
        end

        if (fail_count == 0) begin
            $display("ubx_aiding_frame_builder verification clean");
        end else begin
            $display("ubx_aiding_frame_builder verification failed");
        end
        $finish;
    end

endmodule
